### src/rcr_pkg.sv
// Shared types, constants and pointer helpers for the reorder buffer commit ring.
// Used by rcr_head_cache, rcr_ctrl and reorder_buffer_commit_ring. No dependencies.
package rcr_pkg;

  localparam int RING_DEPTH = 16;
  localparam int PTR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int REG_W     = 7;
  localparam int LREG_W    = 5;
  localparam int IDX_W     = 4;
  localparam int SLOT_W    = 4;
  localparam int OCC_W     = 5;
  localparam int OP_W      = 2;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [REG_W-1:0] NONE_REG = REG_W'(99);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [REG_W-1:0] reg_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Input beat as seen by the control block
  typedef struct packed {
    op_t              op;
    reg_t             old_dest_reg;
    logic             old_dest_valid;
    logic [IDX_W-1:0] entry_index;
    logic             head_reg_locked;
  } in_item_t;

  // Per-entry payload that commit needs back
  typedef struct packed {
    reg_t old_reg;
    logic old_valid;
  } entry_t;

  // Control -> head cache
  typedef struct packed {
    logic   we;
    ptr_t   waddr;
    entry_t wdata;
    logic   hit_head;
    logic   hit_next;
    logic   commit;
    ptr_t   head_next;
  } cache_ctl_t;

  // Head cache -> control
  typedef struct packed {
    entry_t cur;
    entry_t nxt;
  } head_view_t;

  // Control state exported for checks
  typedef struct packed {
    cnt_t                  count;
    ptr_t                  head;
    ptr_t                  tail;
    logic [RING_DEPTH-1:0] live;
  } ring_status_t;

  // Result beat, last member in the lowest bits
  typedef struct packed {
    logic [3:0]        pad;
    reg_t              head_old_reg;
    logic              is_empty;
    logic              is_full;
    logic [OCC_W-1:0]  occupancy;
    reg_t              free_reg;
    logic              free_valid;
    logic              committed;
    logic              accepted;
    logic [SLOT_W-1:0] alloc_slot;
  } result_t;

  function automatic ptr_t inc_ptr(input ptr_t p);
    if (int'(p) + 1 >= RING_DEPTH) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

endpackage

### src/reorder_buffer_commit_ring.sv
// Reorder buffer commit ring: top level with stream handshake and result register.
// Depends on rcr_pkg, rcr_head_cache and rcr_ctrl.
//
// A circular reorder buffer of RING_DEPTH (16) entries. Each input beat carries
// one operation in s_tuser: allocate (stores the old destination mapping at
// the tail and returns the slot), mark executed (sets one entry's executed
// bit), or tick (retires the head when it is live and executed, and releases
// its old physical register unless that register is invalid, is the none code
// 99, or rename reports it locked). Exactly one result beat comes out per
// input beat, in order, registered on acceptance. The block takes one beat
// every cycle: all work is a single pass of pointer and bit updates between
// the ring state and the result register, and the head entry's payload comes
// from a small two-entry cache fed by a registered-read memory, so no read
// latency reaches the beat rate. s_tready drops only while a result waits and
// the sink holds m_tready low. The logical and physical destination fields
// are accepted but not stored, since no output ever reads them back.
module reorder_buffer_commit_ring (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [4:0] logical_reg, [11:5] physical_reg, [18:12] old_dest_reg,
  // [19] old_dest_valid, [23:20] entry_index, [24] head_reg_locked, rest zero
  input  logic [rcr_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] op, rest zero
  input  logic [rcr_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [3:0] alloc_slot, [4] accepted, [5] committed, [6] free_valid,
  // [13:7] free_reg, [18:14] occupancy, [19] is_full, [20] is_empty,
  // [27:21] head_old_reg, rest zero
  output logic [rcr_pkg::OUT_DATA_W-1:0] m_tdata
);
  import rcr_pkg::*;

  logic         fire;
  in_item_t     item;
  cache_ctl_t   ctl;
  head_view_t   view;
  result_t      res;
  result_t      out_q;
  ring_status_t st;

  // Accept whenever the result register is empty or draining this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  // Unpack the beat; logical and physical destinations are dropped.
  assign item.op              = op_t'(s_tuser[OP_W-1:0]);
  assign item.old_dest_reg    = s_tdata[18:12];
  assign item.old_dest_valid  = s_tdata[19];
  assign item.entry_index     = s_tdata[23:20];
  assign item.head_reg_locked = s_tdata[24];

  rcr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .view (view),
    .ctl  (ctl),
    .res  (res),
    .st   (st)
  );

  rcr_head_cache u_cache (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .view (view)
  );

  // Result register: load on accept, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_tdata = out_q;

  // Occupancy always matches the number of live entries.
  a_count_matches_live: assert property (@(posedge clk) disable iff (rst)
    $countones(st.live) == int'(st.count))
    else $error("occupancy does not match live entries");

  // An empty or full ring has head and tail at the same slot.
  a_ptrs_meet: assert property (@(posedge clk) disable iff (rst)
    (st.count == '0 || st.count == CNT_W'(RING_DEPTH)) |-> (st.head == st.tail))
    else $error("head and tail disagree on empty or full ring");

  // A register is released only by a commit.
  a_free_needs_commit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.free_valid) |-> out_q.committed)
    else $error("register freed without commit");

  // A commit never happens on a ring that was empty.
  a_commit_not_empty: assert property (@(posedge clk) disable iff (rst)
    (fire && res.committed) |-> (st.count != '0))
    else $error("commit from an empty ring");

endmodule

### src/rcr_head_cache.sv
// Entry payload memory plus a two-deep cache of the head and the entry after it.
// Depends on rcr_pkg.
module rcr_head_cache (
  input  logic               clk,
  input  logic               rst,
  input  rcr_pkg::cache_ctl_t ctl,
  output rcr_pkg::head_view_t view
);
  import rcr_pkg::*;

  entry_t mem [RING_DEPTH];
  entry_t rdata;
  entry_t byp_data;
  logic   byp;
  entry_t mem_eff;
  entry_t c0, c1;
  entry_t c0_next, c1_next;
  ptr_t   raddr;

  // Prefetch two past the new head; c1 refills from it on commit.
  always_comb begin
    raddr   = inc_ptr(inc_ptr(ctl.head_next));
    mem_eff = byp ? byp_data : rdata;
    c0_next = c0;
    c1_next = c1;
    if (ctl.commit) begin
      c0_next = c1;
      c1_next = mem_eff;
    end else if (ctl.we) begin
      if (ctl.hit_head) begin
        c0_next = ctl.wdata;
      end
      if (ctl.hit_next) begin
        c1_next = ctl.wdata;
      end
    end
  end

  assign view.cur = c0;
  assign view.nxt = c0_next;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata    <= mem[raddr];
    byp_data <= ctl.wdata;
    c0       <= c0_next;
    c1       <= c1_next;
  end

  // Read returns old data on a same-address write; forward the write instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= ctl.we && (ctl.waddr == raddr);
    end
  end

endmodule

### src/rcr_ctrl.sv
// Ring pointers, live and executed bits, occupancy, and the per-beat result.
// Depends on rcr_pkg; drives rcr_head_cache through cache_ctl_t.
module rcr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  rcr_pkg::in_item_t     item,
  input  rcr_pkg::head_view_t   view,
  output rcr_pkg::cache_ctl_t   ctl,
  output rcr_pkg::result_t      res,
  output rcr_pkg::ring_status_t st
);
  import rcr_pkg::*;

  ptr_t                  head, head_next;
  ptr_t                  tail, tail_next;
  cnt_t                  count, count_next;
  logic [RING_DEPTH-1:0] live, live_next;
  logic [RING_DEPTH-1:0] done, done_next;
  logic                  acc, com, fv;
  reg_t                  fr;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    live_next  = live;
    done_next  = done;
    acc        = 1'b0;
    com        = 1'b0;
    fv         = 1'b0;
    fr         = '0;
    ctl.we     = 1'b0;
    ctl.commit = 1'b0;
    if (fire) begin
      unique case (item.op)
        OP_ALLOC: begin
          if (count < CNT_W'(RING_DEPTH)) begin
            live_next[tail] = 1'b1;
            done_next[tail] = 1'b0;
            tail_next       = inc_ptr(tail);
            count_next      = count + CNT_W'(1);
            acc             = 1'b1;
            ctl.we          = 1'b1;
          end
        end
        OP_MARK: begin
          if (int'(item.entry_index) < RING_DEPTH) begin
            done_next[PTR_W'(item.entry_index)] = 1'b1;
          end
        end
        OP_TICK: begin
          if (live[head] && done[head]) begin
            if (view.cur.old_valid && (view.cur.old_reg != NONE_REG)
                && !item.head_reg_locked) begin
              fv = 1'b1;
              fr = view.cur.old_reg;
            end
            live_next[head] = 1'b0;
            head_next       = inc_ptr(head);
            if (count != '0) begin
              count_next = count - CNT_W'(1);
            end
            com        = 1'b1;
            ctl.commit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    ctl.waddr     = tail;
    ctl.wdata     = '{old_reg: item.old_dest_reg, old_valid: item.old_dest_valid};
    ctl.hit_head  = (tail == head);
    ctl.hit_next  = (tail == inc_ptr(head));
    ctl.head_next = head_next;
  end

  always_comb begin
    res              = '0;
    res.alloc_slot   = acc ? SLOT_W'(tail) : '0;
    res.accepted     = acc;
    res.committed    = com;
    res.free_valid   = fv;
    res.free_reg     = fr;
    res.occupancy    = OCC_W'(count_next);
    res.is_full      = (count_next == CNT_W'(RING_DEPTH));
    res.is_empty     = (count_next == '0);
    res.head_old_reg = live_next[head_next] ? view.nxt.old_reg : '0;
  end

  assign st.count = count;
  assign st.head  = head;
  assign st.tail  = tail;
  assign st.live  = live;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      live  <= '0;
      done  <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      live  <= live_next;
      done  <= done_next;
    end
  end

endmodule
